FILE: rtl/wplm_pkg.sv
// ============================================================================
// wplm_pkg: shared types and constants for the windowed peak level meter
// Request codes, controller states and the controller/datapath command bus.
// ============================================================================
`default_nettype none
package wplm_pkg;

   typedef enum logic [1:0] {
      REQ_SAMPLE = 2'd0,
      REQ_QUERY  = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NONE   = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SAMPLE_RD,
      ST_SAMPLE_WR,
      ST_SCAN_RD,
      ST_SCAN_ACC,
      ST_SCAN_DONE,
      ST_OUT
   } state_type;

   localparam logic [1:0] CSR_NUM_CHANNELS  = 2'd0;
   localparam logic [1:0] CSR_SAMPLE_BITS   = 2'd1;
   localparam logic [1:0] CSR_WINDOW_FRAMES = 2'd2;

   // Controller to datapath commands
   typedef struct packed {
      logic clear_init;   // start clearing sweep
      logic clear_step;   // write zero at clear pointer and advance
      logic latch_req;    // capture the accepted request
      logic smp_read;     // read ring at sample slot
      logic smp_write;    // write sample, update levels and pointers
      logic scan_init;    // start rescan of latched channel
      logic scan_read;    // read ring at scan pointer
      logic scan_acc;     // fold read value into scan max/min
      logic scan_store;   // commit scan result to level registers
      logic peak_load;    // capture peak of the queried channel
      logic out_load;     // load output register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic ch_unused;
      logic ch_stale;
   } status_type;

endpackage
`default_nettype wire

FILE: rtl/wplm_if.sv
// ============================================================================
// wplm_req_if / wplm_rsp_if: valid/ready channels of the peak level meter
// Request channel carries type, sample and channel; response carries levels.
// ============================================================================
`default_nettype none
interface wplm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [15:0] sample;
   logic [2:0]  channel;
   modport source (output valid, output req_type, output sample, output channel,
                   input ready);
   modport sink (input valid, input req_type, input sample, input channel,
                 output ready);
endinterface

interface wplm_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] peak_magnitude;
   logic [16:0] level_frac;
   modport source (output valid, output peak_magnitude, output level_frac,
                   input ready);
   modport sink (input valid, input peak_magnitude, input level_frac,
                 output ready);
endinterface
`default_nettype wire

FILE: rtl/wplm_ctrl.sv
// ============================================================================
// wplm_ctrl: sequencer of the peak level meter
// Steps clear sweep, sample read-modify-write, rescan and level output.
// ============================================================================
`default_nettype none
module wplm_ctrl
   import wplm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic [1:0]  req_type,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   input  wire status_type  status,
   output cmd_type          cmd
);

   state_type state_ff, state_in;
   logic      busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // The output register may still hold a result while a new item is taken.
   logic out_full_ff, out_full_in;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else begin
         out_full_ff <= out_full_in;
      end
   end
   assign rsp_valid = out_full_ff;
   assign busy = 1'b0;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      out_full_in = out_full_ff & ~rsp_ready;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = ~busy;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               unique case (req_code_type'(req_type))
                  REQ_SAMPLE: state_in = ST_SAMPLE_RD;
                  REQ_QUERY:  state_in = ST_SCAN_DONE;
                  REQ_CLEAR: begin
                     cmd.clear_init = 1'b1;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_SAMPLE_RD: begin
            cmd.smp_read = 1'b1;
            state_in = ST_SAMPLE_WR;
         end
         ST_SAMPLE_WR: begin
            cmd.smp_write = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SCAN_DONE: begin
            // entry point of a query: decide on rescan
            if (!status.ch_unused && status.ch_stale) begin
               cmd.scan_init = 1'b1;
               state_in = ST_SCAN_RD;
            end else begin
               cmd.peak_load = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_SCAN_RD: begin
            cmd.scan_read = 1'b1;
            state_in = ST_SCAN_ACC;
         end
         ST_SCAN_ACC: begin
            cmd.scan_acc = 1'b1;
            if (status.scan_last) begin
               cmd.scan_store = 1'b1;
               state_in = ST_SCAN_DONE;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         ST_OUT: begin
            if (!out_full_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               out_full_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == ST_IDLE)
      else $error("ready outside idle");
   a_out_from_query: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_OUT |->
         $past(state_ff) == ST_SCAN_DONE || $past(state_ff) == ST_OUT)
      else $error("output without query");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !out_full_ff || rsp_ready)
      else $error("output overwritten");

endmodule
`default_nettype wire

FILE: rtl/wplm_dp.sv
// ============================================================================
// wplm_dp: datapath of the peak level meter
// Sample ring memory, per-channel levels, pointers, rescan and level fraction.
// ============================================================================
`default_nettype none
module wplm_dp
   import wplm_pkg::*;
#(
   parameter int MAX_CHANNELS = 8,
   parameter int BUFFER_DEPTH = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output status_type       status,
   input  wire logic [1:0]  req_type,
   input  wire logic [15:0] req_sample,
   input  wire logic [2:0]  req_channel,
   input  wire logic [3:0]  num_channels,
   input  wire logic        sample_bits,
   input  wire logic [14:0] window_frames,
   output logic [15:0]      peak_magnitude,
   output logic [16:0]      level_frac
);

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int LW = AW + 1;
   localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int NW = $clog2(MAX_CHANNELS + 1);
   localparam int PW = (15 + NW > LW) ? 15 + NW : LW;

   logic [15:0] ring [BUFFER_DEPTH];
   logic [15:0] rd_data_ff;

   logic [15:0] max_ff [MAX_CHANNELS];
   logic [15:0] min_ff [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] stale_ff;
   logic [LW-1:0] base_ff;
   logic [CW-1:0] cif_ff;
   logic [AW-1:0] clr_ff;
   logic [15:0]   smp_ff;
   logic [2:0]    ch_ff;
   logic [LW-1:0] scan_ff;
   logic signed [15:0] smax_ff, smin_ff;
   logic signed [15:0] smax_in, smin_in;
   logic signed [15:0] rv;
   logic          first_ff;
   logic [LW-1:0] len_ff;
   logic [NW-1:0] nch_ff;

   // Active channel count and window length, registered (config is static).
   logic [NW-1:0] nch;
   logic [LW-1:0] len;
   always_comb begin
      nch = (num_channels == 4'd0) ? NW'(1)
          : (32'(num_channels) > MAX_CHANNELS) ? NW'(MAX_CHANNELS) : NW'(num_channels);
   end

   // BUFFER_DEPTH mod n for each channel count n
   logic [NW-1:0] depth_mod [MAX_CHANNELS+1];
   assign depth_mod[0] = '0;
   for (genvar k = 1; k <= MAX_CHANNELS; k++) begin : g_depth_mod
      localparam int DEPTH_MOD_K = BUFFER_DEPTH % k;
      assign depth_mod[k] = NW'(DEPTH_MOD_K);
   end

   // frames clip: frames*nch <= depth, found by comparing product
   logic [PW-1:0] prod;
   logic [14:0]   frames_c;
   always_comb begin
      frames_c = (window_frames == 15'd0) ? 15'd1 : window_frames;
      prod = PW'(frames_c) * PW'(nch_ff);
      if (prod > PW'(BUFFER_DEPTH)) len = LW'(BUFFER_DEPTH) - LW'(depth_mod[nch_ff]);
      else len = LW'(prod);
   end
   always_ff @(posedge clock) begin
      nch_ff <= nch;
      len_ff <= len;
   end

   // Sample slot after out-of-range pointer restart
   logic [CW-1:0] cif_eff;
   logic [LW-1:0] base_eff;
   always_comb begin
      cif_eff  = (32'(cif_ff) >= 32'(nch_ff)) ? '0 : cif_ff;
      base_eff = (32'(base_ff) + 32'(nch_ff) > 32'(len_ff)) ? '0 : base_ff;
   end
   logic [AW-1:0] smp_addr;
   assign smp_addr = AW'(base_eff + LW'(cif_eff));

   logic signed [15:0] v;
   assign v = sample_bits ? $signed(smp_ff) : $signed({8'd0, smp_ff[7:0]} - 16'd128);

   // Ring port
   always_ff @(posedge clock) begin
      if (cmd.clear_step) ring[clr_ff] <= '0;
      else if (cmd.smp_write) ring[smp_addr] <= v;
      if (cmd.smp_read) rd_data_ff <= ring[smp_addr];
      else if (cmd.scan_read) rd_data_ff <= ring[AW'(scan_ff)];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         smp_ff <= req_sample;
         ch_ff  <= req_channel;
      end
   end

   logic [CW-1:0] qch;
   assign qch = CW'(ch_ff);

   // Rescan fold, including the value read for the current slot
   assign rv = $signed(rd_data_ff);
   always_comb begin
      smax_in = (first_ff || rv > smax_ff) ? rv : smax_ff;
      smin_in = (first_ff || rv < smin_ff) ? rv : smin_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_init) begin
         clr_ff <= '0;
         stale_ff <= '1;
         base_ff <= '0;
         cif_ff <= '0;
         for (int c = 0; c < MAX_CHANNELS; c++) begin
            max_ff[c] <= '0;
            min_ff[c] <= '0;
         end
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + AW'(1);
         if (cmd.smp_write) begin
            if ($signed(rd_data_ff) == $signed(max_ff[cif_eff]) ||
                $signed(rd_data_ff) == $signed(min_ff[cif_eff]))
               stale_ff[cif_eff] <= 1'b1;
            if (v > $signed(max_ff[cif_eff])) max_ff[cif_eff] <= v;
            if (v < $signed(min_ff[cif_eff])) min_ff[cif_eff] <= v;
            if (32'(cif_eff) + 1 >= 32'(nch_ff)) begin
               cif_ff <= '0;
               base_ff <= (base_eff + LW'(nch_ff) >= len_ff) ? '0 : base_eff + LW'(nch_ff);
            end else begin
               cif_ff <= cif_eff + CW'(1);
               base_ff <= base_eff;
            end
         end
         if (cmd.scan_store) begin
            max_ff[qch] <= smax_in;
            min_ff[qch] <= smin_in;
            stale_ff[qch] <= 1'b0;
         end
      end
   end

   // Rescan
   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ff <= LW'(ch_ff);
         first_ff <= 1'b1;
      end else if (cmd.scan_acc) begin
         scan_ff <= scan_ff + LW'(nch_ff);
         first_ff <= 1'b0;
         smax_ff <= smax_in;
         smin_ff <= smin_in;
      end
   end

   // Level fraction (2*pk+1)*65536/full from m = 2*pk+1, no divider needed.
   // 16-bit: 65536/65535 = 1 + 1/65535, so the quotient is m, plus one once
   // m reaches 65535, which already clamps to full scale.
   // 8-bit: 65536 = 257*255 + 1, so below m = 255 the quotient is 257*m and
   // from there on it clamps to full scale.
   logic [16:0] pk_ff;
   logic        unused_ch_ff;
   logic signed [16:0] mxs, mns, pk;
   logic [16:0] m, frac;
   always_comb begin
      mxs = 17'($signed(max_ff[qch]));
      mns = 17'($signed(min_ff[qch]));
      pk = (mns < 0) ? -mns : mns;
      if (mxs > pk) pk = mxs;
      m = {pk_ff[15:0], 1'b1};
      if (sample_bits) frac = (m >= 17'd65535) ? 17'd65536 : m;
      else frac = (m >= 17'd255) ? 17'd65536 : (17'(m[7:0]) << 8) + 17'(m[7:0]);
   end
   always_ff @(posedge clock) begin
      if (cmd.peak_load) begin
         pk_ff <= status.ch_unused ? 17'd0 : 17'(pk);
         unused_ch_ff <= status.ch_unused;
      end
      if (cmd.out_load) begin
         peak_magnitude <= pk_ff[15:0];
         level_frac <= unused_ch_ff ? 17'd0 : frac;
      end
   end

   assign status.clear_last = (clr_ff == AW'(BUFFER_DEPTH - 1));
   assign status.scan_last  = (32'(scan_ff) + 32'(nch_ff) >= 32'(len_ff));
   assign status.ch_unused  = (32'(ch_ff) >= 32'(nch_ff));
   assign status.ch_stale   = stale_ff[qch];

   logic unused_rt;
   assign unused_rt = ^req_type;

   a_store_used: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_store |-> !status.ch_unused)
      else $error("rescan of unused channel");
   a_scan_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_read |-> scan_ff < len_ff)
      else $error("scan outside window");
   a_slot_in_window: assert property (@(posedge clock) disable iff (reset)
      cmd.smp_write |-> 32'(smp_addr) < 32'(len_ff))
      else $error("sample slot outside window");

endmodule
`default_nettype wire

FILE: rtl/windowed_peak_level_meter_top.sv
// ============================================================================
// windowed_peak_level_meter_top: sliding-window multichannel peak meter
// APB-configured meter with request and response valid/ready channels.
// ============================================================================
// A sample passes through accept, ring read and ring write, since the old
// value at the slot is read from the single-port ring before it is replaced.
// A query passes through accept, rescan decision and output load; a stale
// channel first does one ring read and one fold for each of its window slots
// (frames) and commits the rebuilt levels with the last fold. The level
// fraction is formed from the peak by shifts and compares, without a divider.
// A query also holds in its output load while the output register keeps an
// unaccepted result. Clear and reset sweep all ring slots, requests held off.
// Configuration must be written only while idle; the block does not check it.
`default_nettype none
module windowed_peak_level_meter_top
   import wplm_pkg::*;
#(
   parameter int MAX_CHANNELS = 8,
   parameter int BUFFER_DEPTH = 16384
) (
   input  wire logic        clock,
   input  wire logic        reset,
   wplm_req_if.sink         req,
   wplm_rsp_if.source       rsp,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic [3:0]  num_channels_ff;
   logic        sample_bits_ff;
   logic [14:0] window_frames_ff;
   cmd_type     cmd;
   status_type  status;

   assign csr_pready = 1'b1;

   // Hold register values; write on the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         num_channels_ff  <= 4'd2;
         sample_bits_ff   <= 1'b1;
         window_frames_ff <= 15'd4096;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (csr_paddr[3:2])
            CSR_NUM_CHANNELS:  num_channels_ff  <= csr_pwdata[3:0];
            CSR_SAMPLE_BITS:   sample_bits_ff   <= csr_pwdata[0];
            CSR_WINDOW_FRAMES: window_frames_ff <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         CSR_NUM_CHANNELS:  csr_prdata = {28'd0, num_channels_ff};
         CSR_SAMPLE_BITS:   csr_prdata = {31'd0, sample_bits_ff};
         CSR_WINDOW_FRAMES: csr_prdata = {17'd0, window_frames_ff};
         default:           csr_prdata = '0;
      endcase
   end

   logic unused_addr;
   assign unused_addr = ^csr_paddr[1:0];

   wplm_ctrl u_ctrl (
      .clock, .reset,
      .req_valid (req.valid),
      .req_type  (req.req_type),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status,
      .cmd
   );

   wplm_dp #(.MAX_CHANNELS(MAX_CHANNELS), .BUFFER_DEPTH(BUFFER_DEPTH)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_type       (req.req_type),
      .req_sample     (req.sample),
      .req_channel    (req.channel),
      .num_channels   (num_channels_ff),
      .sample_bits    (sample_bits_ff),
      .window_frames  (window_frames_ff),
      .peak_magnitude (rsp.peak_magnitude),
      .level_frac     (rsp.level_frac)
   );

   // An ignored request keeps the block idle, so only real work drops ready.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready && req.req_type != REQ_NONE |=> !req.ready)
      else $error("back-to-back accept");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.level_frac))
      else $error("response dropped");
   a_frac_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.level_frac <= 17'd65536)
      else $error("level out of range");

endmodule
`default_nettype wire

FILE: tb/sv/tb_windowed_peak_level_meter_top.sv
// ============================================================================
// tb_windowed_peak_level_meter_top: testbench of the windowed peak level meter
// Drives samples, level queries and clears through the request channel under
// several register settings. A scoreboard keeps its own copy of the ring,
// the level registers and the pointers, predicts each query's peak and level
// fraction, and checks every response beat in order.
// ============================================================================
`default_nettype none
module tb_windowed_peak_level_meter_top
   import wplm_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH_MAX = 8;
   localparam int DEPTH   = 16384;

   typedef struct {
      bit [15:0] peak;
      bit [16:0] frac;
   } level_reading_type;

   // Scoreboard: mirror of the meter state plus the queue of pending readings.
   class level_scoreboard;
      bit [15:0]         ring [DEPTH];
      bit [15:0]         max_lvl [NCH_MAX];
      bit [15:0]         min_lvl [NCH_MAX];
      bit                stale [NCH_MAX];
      int                base_slot;
      int                frame_ch;
      int                cfg_nch;
      int                cfg_bits;
      int                cfg_frames;
      level_reading_type pending [$];
      int                errors;

      function void wipe();
         foreach (ring[i]) ring[i] = '0;
         for (int c = 0; c < NCH_MAX; c++) begin
            max_lvl[c] = '0;
            min_lvl[c] = '0;
            stale[c] = 1'b1;
         end
         base_slot = 0;
         frame_ch = 0;
      endfunction

      function void init();
         cfg_nch = 2;
         cfg_bits = 1;
         cfg_frames = 4096;
         errors = 0;
         wipe();
      endfunction

      function void set_reg(logic [1:0] idx, bit [31:0] val);
         case (idx)
            CSR_NUM_CHANNELS: cfg_nch = val[3:0];
            CSR_SAMPLE_BITS: cfg_bits = val[0];
            CSR_WINDOW_FRAMES: cfg_frames = val[14:0];
            default: ;
         endcase
      endfunction

      function int sx(bit [15:0] x);
         return int'($signed(x));
      endfunction

      function int active_ch();
         if (cfg_nch < 1) return 1;
         if (cfg_nch > NCH_MAX) return NCH_MAX;
         return cfg_nch;
      endfunction

      function int used_slots(int n);
         int f;
         f = cfg_frames;
         if (f < 1) f = 1;
         if (f > DEPTH / n) f = DEPTH / n;
         return f * n;
      endfunction

      function void store_sample(bit [15:0] raw);
         int n, len, ch, idx, old, v;
         n = active_ch();
         len = used_slots(n);
         if (frame_ch >= n) frame_ch = 0;
         if (base_slot + n > len) base_slot = 0;
         ch = frame_ch;
         idx = base_slot + ch;
         old = sx(ring[idx]);
         if (old == sx(max_lvl[ch]) || old == sx(min_lvl[ch])) stale[ch] = 1'b1;
         v = cfg_bits ? sx(raw) : int'(raw[7:0]) - 128;
         ring[idx] = v[15:0];
         if (v > sx(max_lvl[ch])) max_lvl[ch] = v[15:0];
         if (v < sx(min_lvl[ch])) min_lvl[ch] = v[15:0];
         frame_ch = ch + 1;
         if (frame_ch >= n) begin
            frame_ch = 0;
            base_slot += n;
            if (base_slot >= len) base_slot = 0;
         end
      endfunction

      function level_reading_type read_level(int ch);
         level_reading_type r;
         int n, len, mx, mn, pk;
         longint full, fr;
         n = active_ch();
         r.peak = '0;
         r.frac = '0;
         if (ch >= n) return r;
         len = used_slots(n);
         if (stale[ch]) begin
            stale[ch] = 1'b0;
            mx = sx(ring[ch]);
            mn = mx;
            for (int i = ch; i < len; i += n) begin
               if (sx(ring[i]) > mx) mx = sx(ring[i]);
               if (sx(ring[i]) < mn) mn = sx(ring[i]);
            end
            max_lvl[ch] = mx[15:0];
            min_lvl[ch] = mn[15:0];
         end
         mn = sx(min_lvl[ch]);
         mx = sx(max_lvl[ch]);
         pk = mn < 0 ? -mn : mn;
         if (mx > pk) pk = mx;
         full = cfg_bits ? 65535 : 255;
         fr = (longint'(2 * pk + 1) * 65536) / full;
         if (fr > 65536) fr = 65536;
         r.peak = pk[15:0];
         r.frac = fr[16:0];
         return r;
      endfunction

      // Note one accepted request beat.
      function void note_request(req_code_type t, bit [15:0] smp, bit [2:0] ch);
         case (t)
            REQ_SAMPLE: store_sample(smp);
            REQ_QUERY: pending.push_back(read_level(ch));
            REQ_CLEAR: wipe();
            default: ;
         endcase
      endfunction

      task report(string what, longint got, longint want);
         $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
         errors++;
      endtask

      // Check one accepted response beat against the oldest reading.
      task check_reading(bit [15:0] peak, bit [16:0] frac);
         level_reading_type e;
         if (pending.size() == 0) begin
            report("unexpected response", peak, -1);
            return;
         end
         e = pending.pop_front();
         if (peak != e.peak) report("peak_magnitude", peak, e.peak);
         if (frac != e.frac) report("level_frac", frac, e.frac);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   wplm_req_if req ();
   wplm_rsp_if rsp ();

   windowed_peak_level_meter_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .rsp         (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   level_scoreboard sb = new();

   int  burst_left = 0;   // beats left in the current sender burst
   int  hold_request = 0; // cycles of receiver hold-off asked by the main flow

   // 20 ns clock.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Generous run limit: several clears, long rescans and stalls included.
   initial begin
      #80ms;
      $display("TB_ERROR");
      $finish;
   end

   // Receiver: stall on a pattern of its own, with one long hold-off on demand.
   initial begin
      int ready_pct;
      int held;
      ready_pct = 100;
      held = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            held = hold_request;
            hold_request = 0;
         end
         if (($urandom & 255) == 0) begin
            case ($urandom_range(0, 2))
               0: ready_pct = 100;
               1: ready_pct = 60;
               default: ready_pct = 20;
            endcase
         end
         if (held > 0) begin
            held--;
            rsp.ready <= 1'b0;
         end else begin
            rsp.ready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   // Check every response beat at the rising edge.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) sb.check_reading(rsp.peak_magnitude, rsp.level_frac);
   end

   // APB write: setup cycle, then access cycle; pready is always high.
   task csr_write(logic [1:0] idx, bit [31:0] val);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Offer one request beat; open a random gap between bursts.
   task send_req(req_code_type t, bit [15:0] smp, bit [2:0] ch);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      @(negedge clock);
      req.valid <= 1'b1;
      req.req_type <= t;
      req.sample <= smp;
      req.channel <= ch;
      do @(posedge clock); while (!req.ready);
      sb.note_request(t, smp, ch);
      burst_left--;
   endtask

   // Drop valid and wait until every expected reading has arrived.
   task drain();
      @(negedge clock);
      req.valid <= 1'b0;
      burst_left = 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function bit [15:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h00FF;
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // One setting: write all registers, then random requests.
   task run_setting(bit [31:0] nch, bit [31:0] bits, bit [31:0] frames,
                    int count, int query_pct, bit pause_mid, bit hold_mid);
      int r;
      csr_write(CSR_NUM_CHANNELS, nch);
      csr_write(CSR_SAMPLE_BITS, bits);
      csr_write(CSR_WINDOW_FRAMES, frames);
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) drain();
         if (hold_mid && i == count / 2) hold_request = 400;
         r = $urandom_range(0, 999);
         if (r < query_pct * 10)
            send_req(REQ_QUERY, 16'($urandom), 3'($urandom));
         else if (r < query_pct * 10 + 5)
            send_req(REQ_CLEAR, 16'($urandom), 3'($urandom));
         else if (r < query_pct * 10 + 20)
            send_req(REQ_NONE, 16'($urandom), 3'($urandom));
         else
            send_req(REQ_SAMPLE, rand_sample(), 3'($urandom));
      end
      // A closing query retires any clear sweep before the next register write.
      send_req(REQ_QUERY, '0, '0);
      drain();
      repeat (50) @(posedge clock);
   endtask

   initial begin
      sb.init();
      reset = 1'b1;
      req.valid = 1'b0;
      req.req_type = REQ_SAMPLE;
      req.sample = '0;
      req.channel = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part under the reset setting: two channels, 16-bit samples.
      send_req(REQ_QUERY, '0, 3'd0);          // empty window after reset
      send_req(REQ_SAMPLE, 16'h7FFF, '0);     // largest positive, channel 0
      send_req(REQ_SAMPLE, 16'h8000, '0);     // most negative, channel 1
      send_req(REQ_QUERY, '0, 3'd0);
      send_req(REQ_QUERY, '0, 3'd1);          // clamps to full scale
      send_req(REQ_QUERY, '0, 3'd7);          // unused channel
      send_req(REQ_SAMPLE, 16'hFFFF, '0);
      send_req(REQ_SAMPLE, 16'h0001, '0);
      send_req(REQ_NONE, 16'hFFFF, 3'd7);     // ignored request
      send_req(REQ_QUERY, '0, 3'd1);
      send_req(REQ_CLEAR, '0, '0);
      send_req(REQ_QUERY, '0, 3'd1);          // stale after clear
      send_req(REQ_QUERY, '0, 3'd0);
      drain();
      repeat (50) @(posedge clock);

      // Register sweep: extremes, saturation and clipping; mostly small windows.
      run_setting(1, 1, 1, 150, 20, 1'b1, 1'b0);
      run_setting(8, 0, 16384, 150, 8, 1'b0, 1'b0);
      run_setting(0, 1, 5, 200, 15, 1'b0, 1'b1);
      run_setting(15, 0, 3, 250, 15, 1'b0, 1'b0);
      run_setting(3, 1, 32767, 100, 4, 1'b0, 1'b0);
      run_setting(1, 1, 16384, 50, 4, 1'b0, 1'b0);
      run_setting(5, 0, 7, 350, 15, 1'b1, 1'b1);
      run_setting(2, 1, 9, 300, 15, 1'b0, 1'b0);
      run_setting(4, 1, 2, 250, 20, 1'b0, 1'b0);

      drain();
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire
